[src/rbrc_pkg.sv]
package rbrc_pkg;

	// Table geometry.
	localparam int MAX_BORDERS = 256;
	localparam int IDX_W       = $clog2(MAX_BORDERS);
	localparam int CNT_W       = $clog2(MAX_BORDERS + 1);
	localparam int KEY_W       = 64;
	localparam int RULE_W      = 64;

	// Action codes.
	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_MATCH = 1'b1;

	// Status codes.
	localparam logic STAT_DONE = 1'b0;
	localparam logic STAT_FULL = 1'b1;

	typedef struct packed {
		logic              action;
		logic [KEY_W-1:0]  range_begin;
		logic [KEY_W-1:0]  range_end;
		logic [5:0]        rule_id;
		logic [KEY_W-1:0]  lookup_key;
	} req_t;

	typedef struct packed {
		logic [RULE_W-1:0] match_bits;
		logic              no_match;
		logic              status;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_STEP,
		ST_RULE_RD,
		ST_CHECK,
		ST_MERGE_RD,
		ST_MERGE_WR,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		PH_MATCH,
		PH_BEGIN,
		PH_END
	} phase_t;

	typedef enum logic [1:0] {
		KEY_LOOKUP,
		KEY_BEGIN,
		KEY_END
	} key_sel_t;

	typedef enum logic [1:0] {
		RSP_MATCH,
		RSP_ADD_OK,
		RSP_ADD_FULL
	} rsp_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     capture;
		logic     search_init;
		logic     search_rd;
		logic     search_step;
		logic     save_b;
		logic     save_e;
		logic     rule_rd;
		logic     merge_init;
		logic     merge_rd;
		logic     merge_wr;
		logic     load_rsp;
		key_sel_t key_sel;
		rsp_sel_t rsp_sel;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic search_open;
		logic begin_ne_end;
		logic full;
		logic merge_done;
	} sts_t;

endpackage

[src/range_border_rule_classifier_unit.sv]
// Match: a binary search over the stored borders, then a rule read; the search
// loops over a read state and a compare step state.
// Add: one search per distinct range bound, then a merge sweep that rewrites every border.
// An add rejected as full runs the searches and writes nothing.
// One word is in work at a time; the next word is taken once the result is registered.
// Reset clears the border count and the control state; table contents stay undefined.
module range_border_rule_classifier_unit
	import rbrc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_word,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_word
);

	cmd_t cmd;
	sts_t sts;

	rbrc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_action (req_word.action),
		.req_stall  (req_stall),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	rbrc_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_word (req_word),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_word (rsp_word)
	);

endmodule

[src/rbrc_ram.sv]
module rbrc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/rbrc_datapath.sv]
module rbrc_datapath
	import rbrc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  req_t req_word,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t rsp_word
);

	req_t             req_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic             eq_q;
	logic             eqb_q;
	logic             eqe_q;
	logic [CNT_W-1:0] rem_q;
	logic [IDX_W-1:0] w_q;
	logic             pendb_q;
	logic             pende_q;
	logic             bgt_q;
	rsp_t             rsp_q;

	logic [CNT_W:0]   mid_sum;
	logic [CNT_W-1:0] mid;
	logic [CNT_W-1:0] lo_m1;
	logic [CNT_W-1:0] rem_m1;
	logic [KEY_W-1:0] key;
	logic [1:0]       need;
	logic [CNT_W:0]   total;
	logic             ins_b;
	logic             ins_e;
	logic             re_val;
	logic             re_rule;
	logic [IDX_W-1:0] raddr;
	logic [KEY_W-1:0] rd_val;
	logic [RULE_W-1:0] rd_rule;
	logic             pend_any;
	logic [KEY_W-1:0] top_key;
	logic             old_first;
	logic [KEY_W-1:0] wval;
	logic [RULE_W-1:0] others;
	logic [RULE_W-1:0] bit_mask;
	logic [RULE_W-1:0] wrule;

	// Search midpoint and index helpers.
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[CNT_W:1];
	assign lo_m1   = lo_q - CNT_W'(1);
	assign rem_m1  = rem_q - CNT_W'(1);

	// Key under search.
	always_comb begin
		case (cmd.key_sel)
			KEY_BEGIN: key = req_q.range_begin;
			KEY_END:   key = req_q.range_end;
			default:   key = req_q.lookup_key;
		endcase
	end

	// New borders needed by an add.
	assign ins_b = !eqb_q;
	assign ins_e = (req_q.range_begin != req_q.range_end) && !eqe_q;
	assign need  = 2'(ins_b) + 2'(ins_e);
	assign total = {1'b0, count_q} + (CNT_W+1)'(need);

	// Memory read port.
	assign re_val  = cmd.search_rd || cmd.merge_rd;
	assign re_rule = cmd.rule_rd || cmd.merge_rd;
	always_comb begin
		if (cmd.search_rd) begin
			raddr = mid[IDX_W-1:0];
		end else if (cmd.rule_rd) begin
			raddr = lo_m1[IDX_W-1:0];
		end else begin
			raddr = rem_m1[IDX_W-1:0];
		end
	end

	// Merge write: old entries and new borders, highest value first.
	assign pend_any  = pendb_q || pende_q;
	assign top_key   = (pendb_q && (!pende_q || bgt_q)) ? req_q.range_begin
	                                                      : req_q.range_end;
	assign old_first = (rem_q != '0) && (!pend_any || (rd_val > top_key));
	assign wval      = old_first ? rd_val : top_key;
	assign others    = (rem_q != '0) ? rd_rule : '0;
	assign bit_mask  = RULE_W'(1) << req_q.rule_id;
	assign wrule     = (others & ~bit_mask) |
	                   (((wval >= req_q.range_begin) && (wval < req_q.range_end))
	                    ? bit_mask : '0);

	rbrc_ram #(.WIDTH(KEY_W), .DEPTH(MAX_BORDERS)) u_value_ram (
		.clk   (clk),
		.we    (cmd.merge_wr),
		.waddr (w_q),
		.wdata (wval),
		.re    (re_val),
		.raddr (raddr),
		.rdata (rd_val)
	);

	rbrc_ram #(.WIDTH(RULE_W), .DEPTH(MAX_BORDERS)) u_rule_ram (
		.clk   (clk),
		.we    (cmd.merge_wr),
		.waddr (w_q),
		.wdata (wrule),
		.re    (re_rule),
		.raddr (raddr),
		.rdata (rd_rule)
	);

	// Border count is the only state cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.merge_init) begin
			count_q <= total[CNT_W-1:0];
		end
	end

	// Search, merge and result registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_word;
		end
		if (cmd.search_init) begin
			lo_q <= '0;
			hi_q <= count_q;
			eq_q <= 1'b0;
		end else if (cmd.search_step) begin
			if (rd_val <= key) begin
				lo_q <= mid + CNT_W'(1);
				eq_q <= (rd_val == key);
			end else begin
				hi_q <= mid;
			end
		end
		if (cmd.save_b) begin
			eqb_q <= eq_q;
		end
		if (cmd.save_e) begin
			eqe_q <= eq_q;
		end
		if (cmd.merge_init) begin
			rem_q   <= count_q;
			w_q     <= total[IDX_W-1:0] - IDX_W'(1);
			pendb_q <= ins_b;
			pende_q <= ins_e;
			bgt_q   <= req_q.range_begin > req_q.range_end;
		end else if (cmd.merge_wr) begin
			w_q <= w_q - IDX_W'(1);
			if (old_first) begin
				rem_q <= rem_m1;
			end else if (pendb_q && pende_q) begin
				if (bgt_q) begin
					pendb_q <= 1'b0;
				end else begin
					pende_q <= 1'b0;
				end
			end else begin
				pendb_q <= 1'b0;
				pende_q <= 1'b0;
			end
		end
		if (cmd.load_rsp) begin
			case (cmd.rsp_sel)
				RSP_MATCH: begin
					rsp_q.match_bits <= (lo_q == '0) ? '0 : rd_rule;
					rsp_q.no_match   <= (lo_q == '0);
					rsp_q.status     <= STAT_DONE;
				end
				RSP_ADD_FULL: begin
					rsp_q.match_bits <= '0;
					rsp_q.no_match   <= 1'b0;
					rsp_q.status     <= STAT_FULL;
				end
				default: begin
					rsp_q.match_bits <= '0;
					rsp_q.no_match   <= 1'b0;
					rsp_q.status     <= STAT_DONE;
				end
			endcase
		end
	end

	assign sts.search_open  = lo_q < hi_q;
	assign sts.begin_ne_end = req_q.range_begin != req_q.range_end;
	assign sts.full         = total > (CNT_W+1)'(MAX_BORDERS);
	assign sts.merge_done   = (rem_q == '0) && !pend_any;
	assign rsp_word         = rsp_q;

	// The border count never exceeds the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BORDERS))
		else $error("border count above table size");

	// A merge only starts when the add fits.
	a_merge_fits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge_init |-> !sts.full)
		else $error("merge started on a full table");

	// A merge write always has something left to place.
	a_merge_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge_wr |-> !sts.merge_done)
		else $error("merge write with nothing pending");

endmodule

[src/rbrc_ctrl.sv]
module rbrc_ctrl
	import rbrc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_action,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t   state_q, state_d;
	phase_t   phase_q, phase_d;
	rsp_sel_t sel_q, sel_d;
	logic     valid_q;
	logic     out_free;

	assign out_free  = !valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = valid_q;

	// State, phase, result select and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_MATCH;
			sel_q   <= RSP_ADD_OK;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			sel_q   <= sel_d;
			if (cmd.load_rsp) begin
				valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		sel_d   = sel_q;
		cmd     = '0;
		case (phase_q)
			PH_BEGIN: cmd.key_sel = KEY_BEGIN;
			PH_END:   cmd.key_sel = KEY_END;
			default:  cmd.key_sel = KEY_LOOKUP;
		endcase
		cmd.rsp_sel = sel_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture     = 1'b1;
					cmd.search_init = 1'b1;
					phase_d = (req_action == ACT_MATCH) ? PH_MATCH : PH_BEGIN;
					state_d = ST_SRCH_RD;
				end
			end
			ST_SRCH_RD: begin
				if (sts.search_open) begin
					cmd.search_rd = 1'b1;
					state_d = ST_SRCH_STEP;
				end else begin
					case (phase_q)
						PH_MATCH: state_d = ST_RULE_RD;
						PH_BEGIN: begin
							cmd.save_b = 1'b1;
							if (sts.begin_ne_end) begin
								cmd.search_init = 1'b1;
								phase_d = PH_END;
								state_d = ST_SRCH_RD;
							end else begin
								state_d = ST_CHECK;
							end
						end
						default: begin
							cmd.save_e = 1'b1;
							state_d = ST_CHECK;
						end
					endcase
				end
			end
			ST_SRCH_STEP: begin
				cmd.search_step = 1'b1;
				state_d = ST_SRCH_RD;
			end
			ST_RULE_RD: begin
				cmd.rule_rd = 1'b1;
				sel_d   = RSP_MATCH;
				state_d = ST_FINISH;
			end
			ST_CHECK: begin
				if (sts.full) begin
					sel_d   = RSP_ADD_FULL;
					state_d = ST_FINISH;
				end else begin
					cmd.merge_init = 1'b1;
					state_d = ST_MERGE_RD;
				end
			end
			ST_MERGE_RD: begin
				if (sts.merge_done) begin
					sel_d   = RSP_ADD_OK;
					state_d = ST_FINISH;
				end else begin
					cmd.merge_rd = 1'b1;
					state_d = ST_MERGE_WR;
				end
			end
			ST_MERGE_WR: begin
				cmd.merge_wr = 1'b1;
				state_d = ST_MERGE_RD;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_rsp = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// A result is only loaded when the output register can take it.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_rsp |-> out_free)
		else $error("result loaded over a waiting word");

	// An accepted word always starts a search.
	a_accept_search: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == ST_SRCH_RD))
		else $error("accepted word did not start a search");

	// A search read is always followed by its compare step.
	a_read_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.search_rd |=> cmd.search_step)
		else $error("search read without compare step");

endmodule
